// File: rtl/core/bpc_pkg.sv
// Shared types, codes and reset values for the button press classifier.
package bpc_pkg;

	localparam int unsigned AGE_W = 16;
	localparam int unsigned DEB_W = 10;
	localparam int unsigned THR_W = 16;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 10'd20;
	localparam logic [THR_W-1:0] DOUBLE_GAP_RST = 16'd250;
	localparam logic [THR_W-1:0] SINGLE_MAX_RST = 16'd300;
	localparam logic [THR_W-1:0] LONG_MAX_RST = 16'd5000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 8'd0,
		REG_DOUBLE_GAP = 8'd1,
		REG_SINGLE_MAX = 8'd2,
		REG_LONG_MAX   = 8'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_SINGLE    = 3'd1,
		EV_DOUBLE    = 3'd2,
		EV_LONG      = 3'd3,
		EV_VERY_LONG = 3'd4
	} press_ev_t;

	// Debouncer view handed to the classifier for the beat being processed.
	typedef struct packed {
		logic level;
		logic changed;
	} deb_out_t;

	typedef struct packed {
		logic [THR_W-1:0] double_gap;
		logic [THR_W-1:0] single_max;
		logic [THR_W-1:0] long_max;
	} cls_cfg_t;

	function automatic logic [AGE_W-1:0] age_step(input logic [AGE_W-1:0] a);
		age_step = (a == AGE_MAX) ? AGE_MAX : a + AGE_W'(1);
	endfunction

endpackage

// File: rtl/core/bpc_debounce.sv
// Debouncer: accepts a level change only once the last change is old enough.
module bpc_debounce (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        raw,
	input  logic [bpc_pkg::DEB_W-1:0]   debounce_ms,
	output bpc_pkg::deb_out_t           deb
);

	logic                        level_q;
	logic [bpc_pkg::AGE_W-1:0]   age_q;
	logic [bpc_pkg::AGE_W-1:0]   age_inc;
	logic [bpc_pkg::AGE_W-1:0]   age_n;
	logic                        take;

	always_comb begin
		age_inc = bpc_pkg::age_step(age_q);
		take = (raw != level_q) &&
			(age_inc > {{(bpc_pkg::AGE_W-bpc_pkg::DEB_W){1'b0}}, debounce_ms});
		age_n = take ? '0 : age_inc;
		deb.level = take ? raw : level_q;
		deb.changed = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			age_q <= '0;
		end else if (step) begin
			level_q <= deb.level;
			age_q <= age_n;
		end
	end

`ifndef SYNTHESIS
	a_level_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(level_q)) else $error("level moved without a beat");
	a_age_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && take |=> age_q == '0) else $error("age not restarted on change");
	a_change_age_ok: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> age_q >= {{(bpc_pkg::AGE_W-bpc_pkg::DEB_W){1'b0}}, debounce_ms})
		else $error("change taken too early");
`endif

endmodule

// File: rtl/core/bpc_classify.sv
// Classifier: turns debounced edges and hold times into press events.
module bpc_classify (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  bpc_pkg::deb_out_t   deb,
	input  bpc_pkg::cls_cfg_t   cfg,
	output bpc_pkg::press_ev_t  ev
);

	logic                        seen_q;
	logic                        rp_q;
	logic [bpc_pkg::AGE_W-1:0]   sp_q;
	logic [bpc_pkg::AGE_W-1:0]   sr_q;
	logic [bpc_pkg::AGE_W-1:0]   hold_q;

	logic                        seen_n;
	logic                        rp_n;
	logic [bpc_pkg::AGE_W-1:0]   sp_n;
	logic [bpc_pkg::AGE_W-1:0]   sr_n;
	logic [bpc_pkg::AGE_W-1:0]   hold_n;

	always_comb begin
		ev = bpc_pkg::EV_NONE;
		sp_n = bpc_pkg::age_step(sp_q);
		sr_n = bpc_pkg::age_step(sr_q);
		hold_n = hold_q;
		rp_n = rp_q;
		seen_n = deb.level;
		if (seen_q != deb.level) begin
			if (deb.level) begin
				sp_n = '0;
			end else begin
				sr_n = '0;
				hold_n = sp_n;
				if (rp_q) begin
					ev = bpc_pkg::EV_DOUBLE;
					rp_n = 1'b0;
				end else begin
					rp_n = 1'b1;
				end
			end
		end
		// single beats long beats very long
		priority if (!seen_n && rp_n && sr_n > cfg.double_gap) begin
			rp_n = 1'b0;
			ev = bpc_pkg::EV_SINGLE;
		end else if (!seen_n && rp_n && hold_n >= cfg.single_max &&
			hold_n <= cfg.long_max) begin
			rp_n = 1'b0;
			ev = bpc_pkg::EV_LONG;
		end else if (seen_n && sp_n > cfg.long_max) begin
			rp_n = 1'b0;
			ev = bpc_pkg::EV_VERY_LONG;
		end else begin
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			rp_q <= 1'b0;
			sp_q <= '0;
			sr_q <= '0;
			hold_q <= '0;
		end else if (step) begin
			seen_q <= seen_n;
			rp_q <= rp_n;
			sp_q <= sp_n;
			sr_q <= sr_n;
			hold_q <= hold_n;
		end
	end

`ifndef SYNTHESIS
	a_double_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		ev == bpc_pkg::EV_DOUBLE |-> rp_q) else $error("double without pending");
	a_very_long_held: assert property (@(posedge clk) disable iff (!arst_n)
		ev == bpc_pkg::EV_VERY_LONG |-> deb.level) else $error("very long while up");
	a_event_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && ev != bpc_pkg::EV_NONE |=> !rp_q) else $error("pending kept after event");
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(hold_q)) else $error("hold length moved without a beat");
`endif

endmodule

// File: rtl/core/button_press_classifier.sv
// Top level: input stage, configuration registers and event output register.
//
//  channel | signals                         | width | notes
//  in      | in_valid, in_ready, raw_level   | 1     | one beat per 1 ms tick
//  out     | out_valid, out_ready, press_event | 3   | one beat per input beat
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata | 8/16  | write only, no wait
//
// One beat per cycle sustained while the output is not stalled; an accepted tick
// passes the input register, then classify into the output register.
// Reset clears all debouncer and classifier state and loads default thresholds.
// A stalled output holds the pipeline; the input register keeps taking a beat
// whenever the output register frees up in the same cycle.
module button_press_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              raw_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        press_event,
	input  logic                              cfg_wr_en,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	logic                        valid_s1;
	logic                        raw_s1;
	logic                        advance;
	logic                        step;
	logic                        out_valid_q;
	logic [2:0]                  press_event_q;
	logic [bpc_pkg::DEB_W-1:0]   debounce_q;
	bpc_pkg::cls_cfg_t           cls_cfg_q;
	bpc_pkg::deb_out_t           deb;
	bpc_pkg::press_ev_t          ev;

	assign advance = !out_valid_q || out_ready;
	assign step = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign press_event = press_event_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bpc_pkg::DEBOUNCE_RST;
			cls_cfg_q.double_gap <= bpc_pkg::DOUBLE_GAP_RST;
			cls_cfg_q.single_max <= bpc_pkg::SINGLE_MAX_RST;
			cls_cfg_q.long_max <= bpc_pkg::LONG_MAX_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bpc_pkg::REG_DEBOUNCE: debounce_q <= cfg_wdata[bpc_pkg::DEB_W-1:0];
				bpc_pkg::REG_DOUBLE_GAP: cls_cfg_q.double_gap <= cfg_wdata;
				bpc_pkg::REG_SINGLE_MAX: cls_cfg_q.single_max <= cfg_wdata;
				bpc_pkg::REG_LONG_MAX: cls_cfg_q.long_max <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_level;
		end
		if (step) begin
			press_event_q <= ev;
		end
	end

	bpc_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.raw         (raw_s1),
		.debounce_ms (debounce_q),
		.deb         (deb)
	);

	bpc_classify u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.deb    (deb),
		.cfg    (cls_cfg_q),
		.ev     (ev)
	);

`ifndef SYNTHESIS
	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(press_event_q))
		else $error("result dropped under stall");
	a_no_step_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !out_valid_q || out_ready) else $error("overwrote pending result");
	a_stage_refills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1) else $error("accepted beat lost");
`endif

endmodule
